// ----- design/multi_source_bit_deserializer_macros.svh -----
// Assertion macros for the multi-source bit deserializer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MULTI_SOURCE_BIT_DESERIALIZER_MACROS_SVH
`define MULTI_SOURCE_BIT_DESERIALIZER_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is held.
`define MSBD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MSBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- design/msbd_pkg.sv -----
// Shared types and constants for the multi-source bit deserializer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package msbd_pkg;

  localparam int SRC_W           = 22;
  localparam int SLOT_W          = 3;
  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 3;
  localparam int MAX_SOURCES_DEF = 8;

  localparam logic [CNT_W-1:0]  LAST_BIT = 3'd7;
  localparam logic [BYTE_W-1:0] END_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_BIT_STORED = 3'd1,
    KIND_BYTE_DONE  = 3'd2,
    KIND_MSG_END    = 3'd3,
    KIND_TABLE_FULL = 3'd4,
    KIND_UNKNOWN    = 3'd5
  } kind_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_id;
    logic             bit_value;
  } in_item_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [SLOT_W-1:0] slot_index;
    logic [BYTE_W-1:0] byte_value;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/multi_source_bit_deserializer.sv -----
// Multi-source bit deserializer: slot table, per-source byte assembly.
// Depends on msbd_pkg and multi_source_bit_deserializer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_source_bit_deserializer_macros.svh"

// One bit request is taken every cycle while the output is not stalled, and
// each gives exactly one result. The request lands in an input register,
// then all MAX_SOURCES slots compare their source id in parallel, the lowest
// matching (or, for a new source, lowest free) slot is updated, and the
// result is loaded into the output register. A stalled output holds the
// input register, which then stalls the input channel. Bits are assembled
// LSB first; a completed 0xFF byte ends the message and frees the slot. A
// 1-bit from an unregistered source is reported and dropped. slot_index is
// the slot number modulo 8.
module multi_source_bit_deserializer
  import msbd_pkg::*;
#(
  parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam logic [MAX_SOURCES-1:0] ONE_V = MAX_SOURCES'(1);

  // Input register
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_data_r;
  logic     s1_adv;
  logic     in_accept;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, res;

  // Slot table
  logic [MAX_SOURCES-1:0] valid_r;
  logic [SRC_W-1:0]       src_r     [MAX_SOURCES];
  logic [BYTE_W-1:0]      partial_r [MAX_SOURCES];
  logic [CNT_W-1:0]       cnt_r     [MAX_SOURCES];

  logic [MAX_SOURCES-1:0] match, hit_oh, free_oh, claim_oh;
  logic [BYTE_W-1:0]      lane_acc  [MAX_SOURCES];
  logic                   hit_any, free_any, claim_any;
  logic [BYTE_W-1:0]      hit_acc;
  logic                   hit_last;
  logic [SLOT_W-1:0]      hit_idx, free_idx;
  logic                   msg_end;

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Per-slot compare and accumulate, each lane on its own registers
  always_comb begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      match[i]    = valid_r[i] && (src_r[i] == s1_data_r.source_id);
      lane_acc[i] = partial_r[i] | (BYTE_W'(s1_data_r.bit_value) << cnt_r[i]);
    end
  end

  // Lowest set bit of the match vector, lowest clear bit of the valid vector
  assign hit_oh    = match & (~match + ONE_V);
  assign free_oh   = ~valid_r & (valid_r + ONE_V);
  assign hit_any   = |match;
  assign free_any  = |free_oh;
  assign claim_any = !hit_any && !s1_data_r.bit_value && free_any;
  assign claim_oh  = claim_any ? free_oh : '0;

  always_comb begin
    hit_acc  = '0;
    hit_last = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (hit_oh[i]) begin
        hit_acc  = hit_acc | lane_acc[i];
        hit_last = hit_last | (cnt_r[i] == LAST_BIT);
        hit_idx  = hit_idx | SLOT_W'(i);
      end
      if (free_oh[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
    end
  end

  assign msg_end = hit_any && hit_last && (hit_acc == END_BYTE);

  always_comb begin
    res = '{result_kind: KIND_UNKNOWN, slot_index: '0, byte_value: '0};
    priority if (hit_any) begin
      res.slot_index = hit_idx;
      priority if (!hit_last) begin
        res.result_kind = KIND_BIT_STORED;
      end else if (msg_end) begin
        res.result_kind = KIND_MSG_END;
      end else begin
        res.result_kind = KIND_BYTE_DONE;
        res.byte_value  = hit_acc;
      end
    end else if (s1_data_r.bit_value) begin
      res.result_kind = KIND_UNKNOWN;
    end else if (!free_any) begin
      res.result_kind = KIND_TABLE_FULL;
    end else begin
      res.result_kind = KIND_REGISTERED;
      res.slot_index  = free_idx;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  // Slot occupancy: claim on registration, drop on message end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
        if (claim_oh[i]) begin
          valid_r[i] <= 1'b1;
        end else if (hit_oh[i] && cnt_r[i] == LAST_BIT && lane_acc[i] == END_BYTE) begin
          valid_r[i] <= 1'b0;
        end
      end
    end
  end

  // Slot payload; always written when a slot is claimed
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
        if (claim_oh[i]) begin
          src_r[i]     <= s1_data_r.source_id;
          partial_r[i] <= '0;
          cnt_r[i]     <= '0;
        end else if (hit_oh[i]) begin
          if (cnt_r[i] == LAST_BIT) begin
            partial_r[i] <= '0;
            cnt_r[i]     <= '0;
          end else begin
            partial_r[i] <= lane_acc[i];
            cnt_r[i]     <= cnt_r[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MSBD_ASSERT(a_claim_adds_slot, clk, rst_n, (s1_adv && claim_any) |=> ($countones(valid_r) == $past($countones(valid_r)) + 1), "registration did not occupy exactly one slot")
  `MSBD_ASSERT(a_end_frees_slot, clk, rst_n, (s1_adv && msg_end) |=> ($countones(valid_r) + 1 == $past($countones(valid_r))), "message end did not free exactly one slot")
  `MSBD_ASSERT(a_result_from_stage, clk, rst_n, $rose(out_valid_r) |-> $past(s1_adv), "result appeared without a request leaving the input register")
  `MSBD_ASSERT_ALWAYS(a_reset_empty, clk, (!rst_n) |=> (valid_r == '0 && !s1_valid_r && !out_valid_r), "reset did not clear the table and pipeline")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for the multi-source bit deserializer: directed table, then random bits.
// Depends on msbd_pkg and the multi_source_bit_deserializer top level; results are predicted
// from a slot table kept here, or taken from directed rows that carry their own.
`timescale 1ns / 1ps

module tb;
  import msbd_pkg::*;

  localparam int NSLOT        = MAX_SOURCES_DEF;
  localparam int POOL         = 12;
  localparam int RANDOM_ITEMS = 2000;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // predicted slot table
  logic             slot_live [NSLOT];
  logic [SRC_W-1:0] slot_src  [NSLOT];
  logic [7:0]       slot_acc  [NSLOT];
  logic [2:0]       slot_cnt  [NSLOT];

  logic [SRC_W-1:0] pool_id   [POOL];
  logic [7:0]       plan_byte [POOL];

  row_t      directed_rows[$];
  out_item_t pending_results[$];

  int        issued = 0;
  int        burst_left = 4;
  int        gap_left = 0;
  int        stall_mode = 0;
  logic [15:0] stall_pattern = 16'h0;
  int        cycles = 0;
  int        mismatches = 0;
  int        shown = 0;
  int        i;
  logic      stim_done = 1'b0;
  logic      taken;
  logic      row_typed = 1'b0;
  out_item_t row_want = '0;
  out_item_t predicted;
  out_item_t want;

  multi_source_bit_deserializer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic out_item_t assemble_bit(input in_item_t req);
    out_item_t  res;
    int         hit;
    int         free_slot;
    logic [7:0] acc;
    res = '0;
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < NSLOT; s++) begin
      if (slot_live[s]) begin
        if (hit < 0 && slot_src[s] == req.source_id) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    if (hit < 0) begin
      if (req.bit_value) begin
        res.result_kind = KIND_UNKNOWN;
      end else if (free_slot < 0) begin
        res.result_kind = KIND_TABLE_FULL;
      end else begin
        slot_live[free_slot] = 1'b1;
        slot_src[free_slot]  = req.source_id;
        slot_acc[free_slot]  = 8'd0;
        slot_cnt[free_slot]  = 3'd0;
        res.result_kind = KIND_REGISTERED;
        res.slot_index  = free_slot[2:0];
      end
      return res;
    end
    res.slot_index = hit[2:0];
    acc = slot_acc[hit] | (8'(req.bit_value) << slot_cnt[hit]);
    if (slot_cnt[hit] == LAST_BIT) begin
      slot_acc[hit] = 8'd0;
      slot_cnt[hit] = 3'd0;
      if (acc == END_BYTE) begin
        slot_live[hit] = 1'b0;
        res.result_kind = KIND_MSG_END;
      end else begin
        res.result_kind = KIND_BYTE_DONE;
        res.byte_value  = acc;
      end
    end else begin
      slot_acc[hit] = acc;
      slot_cnt[hit] = slot_cnt[hit] + 3'd1;
      res.result_kind = KIND_BIT_STORED;
    end
    return res;
  endfunction

  // Mostly well-formed messages from a pool of sources; the rest is noise.
  function automatic in_item_t pick_request();
    in_item_t r;
    int       p;
    int       h;
    logic     full;
    full = 1'b1;
    for (int s = 0; s < NSLOT; s++)
      if (!slot_live[s]) full = 1'b0;
    if ($urandom_range(9) == 0) begin
      // stray source: only offer a 0-bit when it cannot claim a slot
      r.source_id = SRC_W'($urandom);
      r.bit_value = full ? 1'($urandom_range(1)) : 1'b1;
      return r;
    end
    p = $urandom_range(POOL - 1);
    r.source_id = pool_id[p];
    h = -1;
    for (int s = 0; s < NSLOT; s++)
      if (h < 0 && slot_live[s] && slot_src[s] == pool_id[p]) h = s;
    if (h < 0) begin
      r.bit_value = ($urandom_range(7) == 0);
    end else begin
      if (slot_cnt[h] == 3'd0)
        plan_byte[p] = ($urandom_range(3) == 0) ? END_BYTE : 8'($urandom);
      r.bit_value = plan_byte[p][slot_cnt[h]];
      if ($urandom_range(49) == 0) r.bit_value = ~r.bit_value;
    end
    return r;
  endfunction

  task automatic put_row(input logic [SRC_W-1:0] src, input logic b, input logic typed,
                         input kind_t k, input logic [2:0] s, input logic [7:0] v);
    row_t row;
    row.req.source_id    = src;
    row.req.bit_value    = b;
    row.typed            = typed;
    row.want.result_kind = k;
    row.want.slot_index  = s;
    row.want.byte_value  = v;
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      // check the result taken at this edge
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result: kind %0d slot %0d byte %02h",
                     out_data.result_kind, out_data.slot_index, out_data.byte_value);
          end
        end else begin
          want = pending_results.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.slot_index !== want.slot_index ||
              out_data.byte_value !== want.byte_value) begin
            mismatches++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: expected kind %0d slot %0d byte %02h, got kind %0d slot %0d byte %02h",
                       want.result_kind, want.slot_index, want.byte_value,
                       out_data.result_kind, out_data.slot_index, out_data.byte_value);
            end
          end
        end
      end

      // receiver stall, changing character periodically
      if (cycles % 200 == 0) begin
        stall_mode = $urandom_range(2);
        stall_pattern = 16'($urandom);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= stall_pattern[cycles % 16];
        default: out_stall <= ($urandom_range(3) != 0);
      endcase

      taken = in_valid && !in_stall;
      if (taken) begin
        predicted = assemble_bit(in_data);
        pending_results.push_back(row_typed ? row_want : predicted);
      end
      if (!in_valid || taken) begin
        if (issued >= directed_rows.size() + RANDOM_ITEMS) begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          if (issued < directed_rows.size()) begin
            in_data <= directed_rows[issued].req;
            row_typed = directed_rows[issued].typed;
            row_want  = directed_rows[issued].want;
          end else begin
            in_data <= pick_request();
            row_typed = 1'b0;
          end
          issued++;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  initial begin
    for (i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0;
      slot_src[i]  = '0;
      slot_acc[i]  = 8'd0;
      slot_cnt[i]  = 3'd0;
    end
    for (i = 0; i < POOL; i++) begin
      pool_id[i]   = SRC_W'($urandom);
      plan_byte[i] = 8'd0;
    end

    // unknown source with a 1-bit, then two registrations at the id extremes
    put_row(22'h3FFFFF, 1'b1, 1'b1, KIND_UNKNOWN,    3'd0, 8'h00);
    put_row(22'h000000, 1'b0, 1'b1, KIND_REGISTERED, 3'd0, 8'h00);
    put_row(22'h3FFFFF, 1'b0, 1'b1, KIND_REGISTERED, 3'd1, 8'h00);
    // eight ones: end of message frees slot 0
    for (i = 0; i < 7; i++)
      put_row(22'h000000, 1'b1, 1'b0, KIND_BIT_STORED, 3'd0, 8'h00);
    put_row(22'h000000, 1'b1, 1'b1, KIND_MSG_END, 3'd0, 8'h00);
    // refill: lowest free slot first, then fill the table
    put_row(22'd1, 1'b0, 1'b1, KIND_REGISTERED, 3'd0, 8'h00);
    for (i = 2; i < 8; i++)
      put_row(SRC_W'(i), 1'b0, 1'b0, KIND_REGISTERED, 3'd0, 8'h00);
    put_row(22'd8, 1'b0, 1'b1, KIND_TABLE_FULL, 3'd0, 8'h00);
    // largest byte that is not an end marker
    put_row(22'h3FFFFF, 1'b0, 1'b0, KIND_BIT_STORED, 3'd0, 8'h00);
    for (i = 0; i < 6; i++)
      put_row(22'h3FFFFF, 1'b1, 1'b0, KIND_BIT_STORED, 3'd0, 8'h00);
    put_row(22'h3FFFFF, 1'b1, 1'b1, KIND_BYTE_DONE, 3'd1, 8'hFE);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!(stim_done && pending_results.size() == 0)) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- multi_source_bit_deserializer.f -----
+incdir+design
design/msbd_pkg.sv
design/multi_source_bit_deserializer.sv
tb/tb.sv
